@@ design/trd_pkg.sv @@
`timescale 1ns / 1ps

package trd_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned RELOAD_W = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CNT_W = $clog2(DATA_W);

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RATE_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RATE_HIGH  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PRESC_WIDE = 2'd3;

    localparam logic [DATA_W-1:0] CLK_HZ_RESET   = 32'd72000000;
    localparam logic [DATA_W-1:0] PRESC_FIELD_MAX = 32'h0000_FFFF;
    // multiplicative inverses mod 2^32, exact division by 5 and by 3
    localparam logic [DATA_W-1:0] INV5 = 32'hCCCC_CCCD;
    localparam logic [DATA_W-1:0] INV3 = 32'hAAAA_AAAB;

    typedef struct packed {
        logic load;
        logic div_step;
        logic chk;
        logic fac;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic rate_zero;
        logic period_over;
        logic out_free;
    } sts_t;

endpackage

@@ design/trd_ctrl.sv @@
`timescale 1ns / 1ps

module trd_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  trd_pkg::sts_t sts,
    output logic          idle,
    output trd_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_FAC   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [trd_pkg::CNT_W-1:0] cnt_reg;
    logic [trd_pkg::CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == trd_pkg::CNT_W'(trd_pkg::DATA_W - 1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.rate_zero || !sts.period_over)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.chk    = 1'b1;
                    state_next = S_FAC;
                end
            end
            S_FAC:
            begin
                cmd.fac    = 1'b1;
                state_next = S_CHECK;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_fac_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FAC |=> state_reg == S_CHECK)
        else $error("factor step did not return to check");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == trd_pkg::CNT_W'(trd_pkg::DATA_W - 1))
        |=> state_reg == S_CHECK)
        else $error("divider ran past its last step");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded into a full output register");

endmodule

@@ design/trd_dp.sv @@
`timescale 1ns / 1ps

module trd_dp
#(
    parameter logic [31:0] PERIOD_LIMIT = 32'd65535
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  trd_pkg::cmd_t                        cmd,
    output trd_pkg::sts_t                        sts,
    input  logic                                 cfg_we,
    input  logic [trd_pkg::DATA_W-1:0]           cfg_data,
    input  logic [trd_pkg::DATA_W-1:0]           rate,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [trd_pkg::RELOAD_W-1:0]         reload_value,
    output logic [trd_pkg::DATA_W-1:0]           prescale_value,
    output logic [trd_pkg::STATUS_W-1:0]         status
);

    logic [trd_pkg::DATA_W-1:0]   clk_hz_reg;
    logic [trd_pkg::DATA_W-1:0]   div_reg;
    logic [trd_pkg::DATA_W-1:0]   rem_reg;
    logic [trd_pkg::DATA_W-1:0]   quo_reg;
    logic [trd_pkg::DATA_W-1:0]   presc_reg;
    logic                         rate_zero_reg;
    logic                         div5_reg;
    logic                         div3_reg;
    logic                         valid_reg;
    logic [trd_pkg::RELOAD_W-1:0] reload_reg;
    logic [trd_pkg::DATA_W-1:0]   pval_reg;
    logic [trd_pkg::STATUS_W-1:0] status_reg;

    logic [trd_pkg::DATA_W:0]     rem_shift;
    logic                         rem_ge;
    logic [6:0]                   nib_sum;
    logic [4:0]                   fold;
    logic [3:0]                   mod15;
    logic [trd_pkg::DATA_W-1:0]   inv_sel;
    logic [trd_pkg::DATA_W-1:0]   prod;
    logic [trd_pkg::DATA_W-1:0]   presc_m1;
    logic [trd_pkg::DATA_W-1:0]   period_m1;

    // restoring division step
    assign rem_shift = {rem_reg, quo_reg[trd_pkg::DATA_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    // residue mod 15 through nibble sums, since 16 = 1 mod 15
    always_comb
    begin
        nib_sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            nib_sum = nib_sum + 7'(quo_reg[4*i +: 4]);
        end
        fold  = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
        mod15 = (fold >= 5'd15) ? 4'(fold - 5'd15) : fold[3:0];
    end

    assign inv_sel   = div5_reg ? trd_pkg::INV5 : trd_pkg::INV3;
    assign prod      = quo_reg * inv_sel;
    assign presc_m1  = presc_reg - 1'b1;
    assign period_m1 = quo_reg - 1'b1;

    assign sts.rate_zero   = rate_zero_reg;
    assign sts.period_over = (quo_reg > PERIOD_LIMIT);
    assign sts.out_free    = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= trd_pkg::CLK_HZ_RESET;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                clk_hz_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            div_reg       <= rate;
            rem_reg       <= '0;
            quo_reg       <= clk_hz_reg;
            presc_reg     <= trd_pkg::DATA_W'(1);
            rate_zero_reg <= (rate == '0);
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? trd_pkg::DATA_W'(rem_shift - {1'b0, div_reg})
                              : rem_shift[trd_pkg::DATA_W-1:0];
            quo_reg <= {quo_reg[trd_pkg::DATA_W-2:0], rem_ge};
        end
        if (cmd.chk)
        begin
            div5_reg <= (mod15 == 4'd0) || (mod15 == 4'd5) || (mod15 == 4'd10);
            div3_reg <= (mod15 == 4'd0) || (mod15 == 4'd3) || (mod15 == 4'd6)
                        || (mod15 == 4'd9) || (mod15 == 4'd12);
        end
        if (cmd.fac)
        begin
            priority if (div5_reg)
            begin
                quo_reg   <= prod;
                presc_reg <= {presc_reg[trd_pkg::DATA_W-3:0], 2'b00} + presc_reg;
            end
            else if (div3_reg)
            begin
                quo_reg   <= prod;
                presc_reg <= {presc_reg[trd_pkg::DATA_W-2:0], 1'b0} + presc_reg;
            end
            else
            begin
                quo_reg   <= {1'b0, quo_reg[trd_pkg::DATA_W-1:1]};
                presc_reg <= {presc_reg[trd_pkg::DATA_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            priority if (rate_zero_reg)
            begin
                status_reg <= trd_pkg::ST_RATE_ZERO;
                reload_reg <= '0;
                pval_reg   <= '0;
            end
            else if (quo_reg == '0)
            begin
                status_reg <= trd_pkg::ST_RATE_HIGH;
                reload_reg <= '0;
                pval_reg   <= '0;
            end
            else if (presc_m1 > trd_pkg::PRESC_FIELD_MAX)
            begin
                status_reg <= trd_pkg::ST_PRESC_WIDE;
                reload_reg <= '0;
                pval_reg   <= '0;
            end
            else
            begin
                status_reg <= trd_pkg::ST_OK;
                reload_reg <= period_m1[trd_pkg::RELOAD_W-1:0];
                pval_reg   <= presc_m1;
            end
        end
    end

    assign out_valid      = valid_reg;
    assign reload_value   = reload_reg;
    assign prescale_value = pval_reg;
    assign status         = status_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg != trd_pkg::ST_OK)
        |-> (reload_reg == '0 && pval_reg == '0))
        else $error("error result carries nonzero values");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> valid_reg)
        else $error("stalled result dropped");

    a_presc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.fac) |-> presc_reg != '0)
        else $error("prescaler collapsed to zero");

endmodule

@@ design/timer_rate_divider_split.sv @@
`timescale 1ns / 1ps
// Timer rate divider split.
// Write the timer clock frequency in hertz on the cfg channel (reset value
// 72000000); cfg_ready is always high, write only while the block is idle.
// Each transfer on the s_ channel carries one wanted update rate in hertz.
// The block divides the clock by the rate, then moves factors of 5, 3 or 2
// from the period into the prescaler until the period is within PERIOD_LIMIT.
// One result leaves on the m_ channel per input: reload value, prescale
// value and a status code in m_tuser (ok, rate zero, rate above clock,
// prescaler wider than 16 bits; on error both values are zero).
// The number of factoring steps is at most 16 with the default limit and 24
// with a limit of 255. The bit-serial divider runs first; then the
// test-and-scale loop alternates a check state and a factor state for each
// factoring step, and a final state loads the result into the output.
// One item is worked on at a time; s_tready is high while the controller is
// idle, including while a finished result waits in the output register, so
// the next input is accepted only after the previous result has been loaded.
// When m_tready is low the result holds and a following item stops before
// its result is loaded. Reset empties the output register and returns the
// controller to idle.

module timer_rate_divider_split
#(
    parameter logic [31:0] PERIOD_LIMIT = 32'd65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,   // timer_clock_hz
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] sample_rate_hz
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] reload_value, [47:16] prescale_value
    output logic [1:0]  m_tuser     // [1:0] status
);

    trd_pkg::cmd_t cmd;
    trd_pkg::sts_t sts;
    logic          idle;
    logic          start;

    assign cfg_ready = 1'b1;
    assign s_tready  = idle;
    assign start     = s_tvalid && idle;

    trd_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .idle  (idle),
        .cmd   (cmd)
    );

    trd_dp
    #(
        .PERIOD_LIMIT (PERIOD_LIMIT)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_valid),
        .cfg_data       (cfg_data),
        .rate           (s_tdata),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .reload_value   (m_tdata[15:0]),
        .prescale_value (m_tdata[47:16]),
        .status         (m_tuser)
    );

endmodule
